// ===== hw/rtl/udp_rx_datagram_checker_unit_assert.svh =====
// Assertion macros used by the checker file of the UDP receive datagram checker.
`ifndef UDP_RX_DATAGRAM_CHECKER_UNIT_ASSERT_SVH
`define UDP_RX_DATAGRAM_CHECKER_UNIT_ASSERT_SVH

// Checked on every rising clock edge outside reset.
`define UDPCHK_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("udpchk: assertion failed");

// Checked on every rising clock edge, reset included.
`define UDPCHK_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("udpchk: assertion failed");

`endif

// ===== hw/rtl/udpchk_pkg.sv =====
// Package with types, constants and checksum helpers of the UDP receive datagram checker.
`timescale 1ns / 1ps

package udpchk_pkg;

  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 56;

  localparam logic [16:0] HDR_LEN = 17'd8;
  localparam logic [16:0] SUM_HDR_MIN = 17'd6;
  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;
  localparam logic [15:0] PROTO_UDP = 16'd17;
  localparam logic [15:0] SUM_OK = 16'hFFFF;
  localparam logic [15:0] UDP_HDR_BYTES = 16'd8;

  // Byte offsets inside the UDP header.
  localparam logic [2:0] OFS_SRC_PORT_HI = 3'd0;
  localparam logic [2:0] OFS_SRC_PORT_LO = 3'd1;
  localparam logic [2:0] OFS_DST_PORT_HI = 3'd2;
  localparam logic [2:0] OFS_DST_PORT_LO = 3'd3;
  localparam logic [2:0] OFS_LEN_HI = 3'd4;
  localparam logic [2:0] OFS_LEN_LO = 3'd5;
  localparam logic [2:0] OFS_CSUM_HI = 3'd6;
  localparam logic [2:0] OFS_CSUM_LO = 3'd7;

  typedef enum logic [2:0] {
    STATUS_OK = 3'd0,
    STATUS_SHORT = 3'd1,
    STATUS_BAD_LEN = 3'd2,
    STATUS_BAD_CSUM = 3'd3,
    STATUS_TOO_LONG = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic last_byte;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
  } in_word_t;

  typedef struct packed {
    status_t status;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] data_size;
    logic checksum_skipped;
  } result_t;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[15:0] + {15'd0, t[16]};
  endfunction

  function automatic logic [15:0] oc_sum3(input logic [15:0] a, input logic [15:0] b,
                                          input logic [15:0] c);
    logic [17:0] t;
    logic [16:0] f;
    t = {2'b00, a} + {2'b00, b} + {2'b00, c};
    f = {1'b0, t[15:0]} + {15'd0, t[17:16]};
    return f[15:0] + {15'd0, f[16]};
  endfunction

endpackage

// ===== hw/rtl/udpchk_in_stage.sv =====
// Input register stage of the UDP receive datagram checker.
`timescale 1ns / 1ps

module udpchk_in_stage import udpchk_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic                 s_axis_tlast,
  input  logic                 out_busy,
  output in_word_t             word,
  output logic                 take
);

  logic in_valid;
  logic in_valid_next;
  logic s_accept;

  // A last word waits only while a previous verdict is still held at the output.
  assign take = in_valid && !(word.last_byte && out_busy);
  assign s_axis_tready = !in_valid || take;
  assign s_accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_next = in_valid;
    if (s_accept) begin
      in_valid_next = 1'b1;
    end else if (take) begin
      in_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= in_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      word.data_byte <= s_axis_tdata[7:0];
      word.last_byte <= s_axis_tlast;
      word.src_addr <= s_axis_tdata[39:8];
      word.dst_addr <= s_axis_tdata[71:40];
    end
  end

endmodule

// ===== hw/rtl/udpchk_parse.sv =====
// Header capture, checksum accumulation and verdict logic of the UDP receive datagram checker.
`timescale 1ns / 1ps

module udpchk_parse import udpchk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        take,
  input  in_word_t    word,
  output result_t     result,
  output logic        result_load
);

  logic [15:0] max_payload;
  logic [16:0] byte_count;
  logic [16:0] byte_count_next;
  logic [15:0] data_sum;
  logic [15:0] data_sum_next;
  logic [15:0] pseudo_sum;
  logic [15:0] pseudo_sum_next;
  logic [15:0] declared_len;
  logic [15:0] declared_len_next;
  logic [15:0] recv_checksum;
  logic [15:0] recv_checksum_next;
  logic [15:0] sport;
  logic [15:0] sport_next;
  logic [15:0] dport;
  logic [15:0] dport_next;
  logic [31:0] src_addr;
  logic [31:0] src_addr_next;
  logic [31:0] dst_addr;
  logic [31:0] dst_addr_next;

  logic        in_sum;
  logic [15:0] byte_term;
  logic [15:0] pseudo_term;
  logic [15:0] full_sum;
  logic [17:0] total_bytes;
  logic [15:0] body_len;

  assign result_load = take && word.last_byte;

  always_comb begin
    sport_next = sport;
    dport_next = dport;
    declared_len_next = declared_len;
    recv_checksum_next = recv_checksum;
    src_addr_next = src_addr;
    dst_addr_next = dst_addr;
    pseudo_term = 16'd0;

    if (byte_count == 17'd0) begin
      src_addr_next = word.src_addr;
      dst_addr_next = word.dst_addr;
    end

    // Pseudo-header words are folded in while the header streams by.
    if (byte_count < HDR_LEN) begin
      unique case (byte_count[2:0])
        OFS_SRC_PORT_HI: begin
          sport_next = {word.data_byte, sport[7:0]};
          pseudo_term = word.src_addr[31:16];
        end
        OFS_SRC_PORT_LO: begin
          sport_next = {sport[15:8], word.data_byte};
          pseudo_term = src_addr[15:0];
        end
        OFS_DST_PORT_HI: begin
          dport_next = {word.data_byte, dport[7:0]};
          pseudo_term = dst_addr[31:16];
        end
        OFS_DST_PORT_LO: begin
          dport_next = {dport[15:8], word.data_byte};
          pseudo_term = dst_addr[15:0];
        end
        OFS_LEN_HI: declared_len_next = {word.data_byte, declared_len[7:0]};
        OFS_LEN_LO: declared_len_next = {declared_len[15:8], word.data_byte};
        OFS_CSUM_HI: begin
          recv_checksum_next = {word.data_byte, recv_checksum[7:0]};
          pseudo_term = declared_len;
        end
        OFS_CSUM_LO: recv_checksum_next = {recv_checksum[15:8], word.data_byte};
        default: pseudo_term = 16'd0;
      endcase
    end

    // Even bytes are high halves and odd bytes low halves of big-endian words,
    // so an odd final byte comes out padded with zero on its own.
    in_sum = (byte_count < SUM_HDR_MIN) || (byte_count < {1'b0, declared_len});
    if (!in_sum) begin
      byte_term = 16'd0;
    end else if (byte_count[0]) begin
      byte_term = {8'h00, word.data_byte};
    end else begin
      byte_term = {word.data_byte, 8'h00};
    end

    data_sum_next = oc_add(data_sum, byte_term);
    pseudo_sum_next = oc_add(pseudo_sum, pseudo_term);
    byte_count_next = (byte_count == COUNT_MAX) ? byte_count : byte_count + 17'd1;

    full_sum = oc_sum3(data_sum, byte_term, pseudo_sum);
    total_bytes = {1'b0, byte_count} + 18'd1;
    body_len = declared_len_next - UDP_HDR_BYTES;

    result.status = STATUS_OK;
    result.sport = 16'd0;
    result.dport = 16'd0;
    result.data_size = 16'd0;
    result.checksum_skipped = 1'b0;
    if (total_bytes < {1'b0, HDR_LEN}) begin
      result.status = STATUS_SHORT;
    end else if ((declared_len_next < UDP_HDR_BYTES) ||
                 ({2'b00, declared_len_next} > total_bytes)) begin
      result.status = STATUS_BAD_LEN;
    end else begin
      result.checksum_skipped = (recv_checksum_next == 16'd0);
      if (!result.checksum_skipped && (full_sum != SUM_OK)) begin
        result.status = STATUS_BAD_CSUM;
      end else if (body_len > max_payload) begin
        result.status = STATUS_TOO_LONG;
      end else begin
        result.sport = sport_next;
        result.dport = dport_next;
        result.data_size = body_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= 16'd1472;
      byte_count <= 17'd0;
      data_sum <= 16'd0;
      pseudo_sum <= PROTO_UDP;
    end else begin
      if (cfg_wr_en) begin
        max_payload <= cfg_wr_data;
      end
      if (take) begin
        if (word.last_byte) begin
          byte_count <= 17'd0;
          data_sum <= 16'd0;
          pseudo_sum <= PROTO_UDP;
        end else begin
          byte_count <= byte_count_next;
          data_sum <= data_sum_next;
          pseudo_sum <= pseudo_sum_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sport <= sport_next;
      dport <= dport_next;
      declared_len <= declared_len_next;
      recv_checksum <= recv_checksum_next;
      src_addr <= src_addr_next;
      dst_addr <= dst_addr_next;
    end
  end

endmodule

// ===== hw/rtl/udpchk_out_stage.sv =====
// Result register stage of the UDP receive datagram checker.
`timescale 1ns / 1ps

module udpchk_out_stage import udpchk_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  result_t              result,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  output logic                 busy
);

  result_t held;
  logic    valid_next;

  assign busy = m_axis_tvalid && !m_axis_tready;
  assign m_axis_tdata = {4'd0, held.checksum_skipped, held.data_size, held.dport,
                         held.sport, held.status};

  always_comb begin
    valid_next = m_axis_tvalid;
    if (load) begin
      valid_next = 1'b1;
    end else if (m_axis_tready) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      m_axis_tvalid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

// ===== hw/rtl/udp_rx_datagram_checker_unit.sv =====
// Top level of the UDP receive datagram checker.
`timescale 1ns / 1ps

// The slave stream carries one datagram byte per word, header first; tlast marks
// the final byte, and the IPv4 addresses ride along and are sampled on the first
// byte. For every tlast word the master stream returns one verdict word: status,
// ports, data length and a flag that tells whether the checksum was zero and so
// not checked. Words that are not last produce nothing.
// One word is taken per clock cycle for as long as the verdicts are taken.
// A verdict becomes valid on the master side once its last byte has been accepted
// and taken: the byte sits in the input register while the header and checksum
// logic forms the verdict, which is then loaded into the result register.
// While the receiver stalls, the held verdict waits in the result register and
// non-last bytes keep flowing; the next last byte waits in the input register.
// The user writes the maximum data length through cfg_wr_en and cfg_wr_data only
// while the block is idle; the block does not enforce this. Reset empties both
// registers, restarts the byte count and sets the maximum data length to 1472.

module udp_rx_datagram_checker_unit import udpchk_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [15:0]          cfg_wr_data,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // data_byte [7:0], src_addr [39:8], dst_addr [71:40]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // status [2:0], sport [18:3], dport [34:19], data_size [50:35],
  // checksum_skipped [51], zero [55:52]
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  in_word_t word;
  result_t  result;
  logic     take;
  logic     result_load;
  logic     out_busy;

  udpchk_in_stage u_in_stage (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .out_busy      (out_busy),
    .word          (word),
    .take          (take)
  );

  udpchk_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .take        (take),
    .word        (word),
    .result      (result),
    .result_load (result_load)
  );

  udpchk_out_stage u_out_stage (
    .clk           (clk),
    .rst           (rst),
    .load          (result_load),
    .result        (result),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .busy          (out_busy)
  );

endmodule

// ===== hw/rtl/udpchk_checker.sv =====
// Port-level assertion checker of the UDP receive datagram checker and its bind.
`timescale 1ns / 1ps

`include "udp_rx_datagram_checker_unit_assert.svh"

module udpchk_checker import udpchk_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 cfg_wr_en,
  input logic [15:0]          cfg_wr_data,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [S_TDATA_W-1:0] s_axis_tdata,
  input logic                 s_axis_tlast,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  `UDPCHK_ASSERT_ALWAYS(a_reset_empties_output, rst |=> !m_axis_tvalid)
  `UDPCHK_ASSERT(a_stalled_word_holds,
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
  `UDPCHK_ASSERT(a_status_defined, m_axis_tvalid |-> (m_axis_tdata[2:0] <= STATUS_TOO_LONG))
  `UDPCHK_ASSERT(a_reject_clears_fields,
    (m_axis_tvalid && (m_axis_tdata[2:0] != STATUS_OK)) |-> (m_axis_tdata[50:3] == 48'd0))
  `UDPCHK_ASSERT(a_ready_when_output_empty, !m_axis_tvalid |-> s_axis_tready)

endmodule

bind udp_rx_datagram_checker_unit udpchk_checker u_udpchk_checker (.*);

// ===== tb/udp_rx_datagram_checker_unit_test.sv =====
// Self-checking testbench for the UDP receive datagram checker, with its own verdict predictor.
`timescale 1ns / 1ps

module udp_rx_datagram_checker_unit_test;
  import udpchk_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam logic [15:0] DEFAULT_MAX_DATA = 16'd1472;
  localparam logic [15:0] TOP_MAX_DATA = 16'd65527;

  typedef enum {CK_GOOD, CK_BAD, CK_ZERO, CK_ANY} csum_kind_t;

  typedef struct {
    int cfg;
    int total;
    int decl;
    csum_kind_t ck;
    logic [31:0] sa;
    logic [31:0] da;
    logic [15:0] sp;
    logic [15:0] dp;
    bit typed;
    status_t st;
    int dl;
    bit skip;
  } dgram_plan_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic s_axis_tlast;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  // Predictor state for the datagram in progress.
  logic [16:0] byte_cnt = '0;
  logic [15:0] run_sum = '0;
  logic [7:0] high_byte = '0;
  logic [15:0] udp_len = '0;
  logic [15:0] rx_csum = '0;
  logic [15:0] sport_q = '0;
  logic [15:0] dport_q = '0;
  logic [31:0] src_addr_q = '0;
  logic [31:0] dst_addr_q = '0;
  logic [15:0] max_data = DEFAULT_MAX_DATA;

  result_t due_verdicts[$];
  dgram_plan_t plan[$];
  logic [7:0] dgram_bytes[$];
  bit fixed_valid = 1'b0;
  result_t fixed_verdict = '0;
  bit calm = 1'b0;
  bit stall_ask = 1'b0;
  bit stall_done = 1'b0;
  int unsigned cycle_count = 0;
  int errors = 0;
  int bytes_sent = 0;
  int dgrams_sent = 0;
  int verdicts_seen = 0;
  int status_hits[5] = '{0, 0, 0, 0, 0};

  udp_rx_datagram_checker_unit DUT (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[15:0] + {15'd0, t[16]};
  endfunction

  task automatic track_byte(input logic [7:0] b, input logic last, input logic [31:0] sa,
                            input logic [31:0] da, output bit fire, output result_t v);
    logic [16:0] idx;
    logic [17:0] n;
    logic [15:0] s;
    idx = byte_cnt;
    fire = 1'b0;
    v = '0;
    if (idx == 17'd0) begin
      src_addr_q = sa;
      dst_addr_q = da;
    end
    if (idx < HDR_LEN) begin
      case (idx[2:0])
        OFS_SRC_PORT_HI: sport_q[15:8] = b;
        OFS_SRC_PORT_LO: sport_q[7:0] = b;
        OFS_DST_PORT_HI: dport_q[15:8] = b;
        OFS_DST_PORT_LO: dport_q[7:0] = b;
        OFS_LEN_HI: udp_len[15:8] = b;
        OFS_LEN_LO: udp_len[7:0] = b;
        OFS_CSUM_HI: rx_csum[15:8] = b;
        default: rx_csum[7:0] = b;
      endcase
    end
    if (idx < SUM_HDR_MIN || idx < {1'b0, udp_len}) begin
      if (!idx[0]) begin
        high_byte = b;
      end else begin
        run_sum = ones_add(run_sum, {high_byte, b});
      end
    end
    byte_cnt = (idx < COUNT_MAX) ? idx + 17'd1 : COUNT_MAX;
    if (last) begin
      fire = 1'b1;
      n = {1'b0, idx} + 18'd1;
      if (n < {1'b0, HDR_LEN}) begin
        v.status = STATUS_SHORT;
      end else if (udp_len < UDP_HDR_BYTES || {2'b00, udp_len} > n) begin
        v.status = STATUS_BAD_LEN;
      end else begin
        s = run_sum;
        if (udp_len[0]) s = ones_add(s, {high_byte, 8'h00});
        s = ones_add(s, src_addr_q[31:16]);
        s = ones_add(s, src_addr_q[15:0]);
        s = ones_add(s, dst_addr_q[31:16]);
        s = ones_add(s, dst_addr_q[15:0]);
        s = ones_add(s, PROTO_UDP);
        s = ones_add(s, udp_len);
        v.checksum_skipped = (rx_csum == 16'h0000);
        if (!v.checksum_skipped && s != SUM_OK) begin
          v.status = STATUS_BAD_CSUM;
        end else if (udp_len - UDP_HDR_BYTES > max_data) begin
          v.status = STATUS_TOO_LONG;
        end else begin
          v.status = STATUS_OK;
          v.sport = sport_q;
          v.dport = dport_q;
          v.data_size = udp_len - UDP_HDR_BYTES;
        end
      end
      byte_cnt = '0;
      run_sum = '0;
      high_byte = '0;
      udp_len = '0;
      rx_csum = '0;
      sport_q = '0;
      dport_q = '0;
      src_addr_q = '0;
      dst_addr_q = '0;
    end
  endtask

  task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    bit fire;
    result_t want;
    result_t got;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d verdicts outstanding.", cycle_count,
               due_verdicts.size());
      $display("** udp_rx_datagram_checker_unit: FAILED **");
      $finish;
    end else if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        track_byte(s_axis_tdata[7:0], s_axis_tlast, s_axis_tdata[39:8], s_axis_tdata[71:40],
                   fire, want);
        if (fire) due_verdicts.push_back(fixed_valid ? fixed_verdict : want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '0;
        got.status = status_t'(m_axis_tdata[2:0]);
        got.sport = m_axis_tdata[18:3];
        got.dport = m_axis_tdata[34:19];
        got.data_size = m_axis_tdata[50:35];
        got.checksum_skipped = m_axis_tdata[51];
        verdicts_seen++;
        if (got.status <= STATUS_TOO_LONG) status_hits[got.status]++;
        if (due_verdicts.size() == 0) begin
          errors++;
          $display("%0t ns: verdict word 0x%0h arrived with none expected", $time,
                   m_axis_tdata);
        end else begin
          want = due_verdicts.pop_front();
          check_field("status", {13'd0, want.status}, {13'd0, got.status});
          check_field("sport", want.sport, got.sport);
          check_field("dport", want.dport, got.dport);
          check_field("data_size", want.data_size, got.data_size);
          check_field("checksum_skipped", {15'd0, want.checksum_skipped},
                      {15'd0, got.checksum_skipped});
        end
      end
    end
  end

  // The receiver idles at random and holds off once for a long stretch.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_ask && !stall_done) begin
        stall_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (300) @(negedge clk);
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 13);
      end
    end
  end

  function automatic dgram_plan_t mk_row(input int cfg, input int total, input int decl,
                                         input csum_kind_t ck, input logic [31:0] sa,
                                         input logic [31:0] da, input logic [15:0] sp,
                                         input logic [15:0] dp, input bit typed,
                                         input status_t st, input int dl, input bit skip);
    dgram_plan_t r;
    r.cfg = cfg;
    r.total = total;
    r.decl = decl;
    r.ck = ck;
    r.sa = sa;
    r.da = da;
    r.sp = sp;
    r.dp = dp;
    r.typed = typed;
    r.st = st;
    r.dl = dl;
    r.skip = skip;
    return r;
  endfunction

  task automatic build_dgram(input dgram_plan_t p);
    logic [63:0] hdr;
    logic [15:0] s;
    logic [15:0] c;
    logic [7:0] lo;
    int k;
    int lim;
    hdr = {p.sp, p.dp, p.decl[15:0], 16'h0000};
    dgram_bytes.delete();
    for (k = 0; k < p.total; k++) begin
      dgram_bytes.push_back(k < 8 ? hdr[63 - 8 * k -: 8] : 8'($urandom_range(0, 255)));
    end
    c = 16'($urandom_range(0, 65535));
    if (p.ck == CK_ZERO) begin
      c = 16'h0000;
    end else if (p.ck != CK_ANY) begin
      lim = (p.decl < p.total) ? p.decl : p.total;
      s = 16'h0000;
      for (k = 0; k < lim; k += 2) begin
        lo = (k + 1 < lim) ? dgram_bytes[k + 1] : 8'h00;
        s = ones_add(s, {dgram_bytes[k], lo});
      end
      s = ones_add(s, p.sa[31:16]);
      s = ones_add(s, p.sa[15:0]);
      s = ones_add(s, p.da[31:16]);
      s = ones_add(s, p.da[15:0]);
      s = ones_add(s, PROTO_UDP);
      s = ones_add(s, p.decl[15:0]);
      if (p.ck == CK_GOOD) begin
        c = ~s;
        if (c == 16'h0000) c = 16'hFFFF;
      end else begin
        do c = 16'($urandom_range(1, 65535)); while (ones_add(s, c) == SUM_OK);
      end
    end
    if (p.total > 6) dgram_bytes[6] = c[15:8];
    if (p.total > 7) dgram_bytes[7] = c[7:0];
  endtask

  task automatic put_byte(input logic [7:0] b, input logic last, input logic [31:0] sa,
                          input logic [31:0] da);
    if (!calm && $urandom_range(99) < 13) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {da, sa, b};
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic send_dgram(input dgram_plan_t p);
    int k;
    fixed_valid = p.typed;
    fixed_verdict = '0;
    fixed_verdict.status = p.st;
    fixed_verdict.checksum_skipped = p.skip;
    if (p.st == STATUS_OK) begin
      fixed_verdict.sport = p.sp;
      fixed_verdict.dport = p.dp;
      fixed_verdict.data_size = p.dl[15:0];
    end
    build_dgram(p);
    for (k = 0; k < dgram_bytes.size(); k++) begin
      put_byte(dgram_bytes[k], k == dgram_bytes.size() - 1, k == 0 ? p.sa : $urandom,
               k == 0 ? p.da : $urandom);
    end
    bytes_sent += dgram_bytes.size();
    dgrams_sent++;
  endtask

  // Waits until the block has drained, then writes the maximum data length.
  task automatic write_max_data(input logic [15:0] v);
    s_axis_tvalid <= 1'b0;
    while (due_verdicts.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    max_data = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    dgram_plan_t p;
    int r;
    int pay;
    int rand_dgrams;
    int rand_base;
    logic [15:0] v;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    plan.push_back(mk_row(-1, 8, 8, CK_GOOD, 32'h0, 32'h0, 16'h0, 16'h0,
                          1, STATUS_OK, 0, 0));
    plan.push_back(mk_row(-1, 9, 9, CK_GOOD, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF,
                          1, STATUS_OK, 1, 0));
    plan.push_back(mk_row(-1, 1, 8, CK_ANY, $urandom, $urandom, 16'h1234, 16'h5678,
                          1, STATUS_SHORT, 0, 0));
    plan.push_back(mk_row(-1, 7, 8, CK_ANY, $urandom, $urandom, 16'hABCD, 16'h0035,
                          1, STATUS_SHORT, 0, 0));
    plan.push_back(mk_row(-1, 8, 7, CK_ANY, $urandom, $urandom, 16'h0044, 16'h0043,
                          1, STATUS_BAD_LEN, 0, 0));
    plan.push_back(mk_row(-1, 10, 0, CK_ANY, $urandom, $urandom, 16'h0007, 16'h0009,
                          1, STATUS_BAD_LEN, 0, 0));
    plan.push_back(mk_row(-1, 10, 11, CK_ANY, $urandom, $urandom, 16'h1F90, 16'h0050,
                          1, STATUS_BAD_LEN, 0, 0));
    plan.push_back(mk_row(-1, 12, 12, CK_BAD, $urandom, $urandom, 16'h00A1, 16'h00A2,
                          1, STATUS_BAD_CSUM, 0, 0));
    plan.push_back(mk_row(-1, 12, 12, CK_ZERO, $urandom, $urandom, 16'h0202, 16'h0303,
                          1, STATUS_OK, 4, 1));
    plan.push_back(mk_row(-1, 21, 15, CK_GOOD, $urandom, $urandom, 16'h4000, 16'h8000,
                          0, STATUS_OK, 0, 0));
    plan.push_back(mk_row(4, 13, 13, CK_GOOD, $urandom, $urandom, 16'h0101, 16'h0102,
                          1, STATUS_TOO_LONG, 0, 0));
    plan.push_back(mk_row(-1, 12, 12, CK_ZERO, $urandom, $urandom, 16'h0201, 16'h0202,
                          1, STATUS_OK, 4, 1));
    plan.push_back(mk_row(-1, 13, 13, CK_BAD, $urandom, $urandom, 16'h0301, 16'h0302,
                          1, STATUS_BAD_CSUM, 0, 0));
    plan.push_back(mk_row(0, 8, 8, CK_GOOD, $urandom, $urandom, 16'h7FFF, 16'h8001,
                          1, STATUS_OK, 0, 0));
    plan.push_back(mk_row(-1, 9, 9, CK_ZERO, $urandom, $urandom, 16'h0401, 16'h0402,
                          1, STATUS_TOO_LONG, 0, 1));
    plan.push_back(mk_row(TOP_MAX_DATA, 24, 24, CK_GOOD, $urandom, $urandom,
                          16'hC000, 16'h0001, 1, STATUS_OK, 16, 0));
    plan.push_back(mk_row(-1, 40, 23, CK_GOOD, $urandom, $urandom, 16'h0501, 16'h0502,
                          0, STATUS_OK, 0, 0));

    foreach (plan[k]) begin
      if (plan[k].cfg >= 0) write_max_data(plan[k].cfg[15:0]);
      send_dgram(plan[k]);
    end

    rand_dgrams = 0;
    rand_base = bytes_sent;
    while (bytes_sent - rand_base < 180 || rand_dgrams < 16) begin
      if (rand_dgrams % 8 == 0) begin
        case ($urandom_range(4))
          0: v = 16'h0000;
          1: v = 16'($urandom_range(0, 20));
          2: v = TOP_MAX_DATA;
          3: v = 16'($urandom_range(0, 65527));
          default: v = DEFAULT_MAX_DATA;
        endcase
        write_max_data(v);
      end
      if (rand_dgrams == 4) stall_ask = 1'b1;
      calm = (rand_dgrams >= 8 && rand_dgrams < 14);
      pay = $urandom_range(0, 8);
      p = mk_row(-1, 8 + pay, 8 + pay, CK_GOOD, $urandom, $urandom,
                 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 0, STATUS_OK, 0, 0);
      r = $urandom_range(99);
      if (r < 55) begin
        p.ck = CK_GOOD;
      end else if (r < 63) begin
        p.ck = CK_ZERO;
      end else if (r < 71) begin
        p.ck = CK_BAD;
      end else if (r < 77) begin
        p.total = $urandom_range(1, 7);
        p.ck = CK_ANY;
      end else if (r < 83) begin
        p.ck = CK_ANY;
        case ($urandom_range(2))
          0: p.decl = $urandom_range(0, 7);
          1: p.decl = p.total + $urandom_range(1, 300);
          default: p.decl = $urandom_range(0, 65535);
        endcase
      end else if (r < 91) begin
        p.total = p.decl + $urandom_range(1, 6);
      end else if (max_data < 40) begin
        p.decl = 8 + max_data + $urandom_range(1, 3);
        p.total = p.decl;
        p.ck = $urandom_range(1) ? CK_GOOD : CK_ZERO;
      end
      send_dgram(p);
      rand_dgrams++;
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (due_verdicts.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    $display("Sent %0d datagrams in %0d bytes under several maximum data lengths.",
             dgrams_sent, bytes_sent);
    $display("Verdicts %0d: ok %0d, short %0d, bad length %0d, bad checksum %0d, long %0d.",
             verdicts_seen, status_hits[STATUS_OK], status_hits[STATUS_SHORT],
             status_hits[STATUS_BAD_LEN], status_hits[STATUS_BAD_CSUM],
             status_hits[STATUS_TOO_LONG]);
    if (errors == 0) begin
      $display("** udp_rx_datagram_checker_unit: PASSED **");
    end else begin
      $display("** udp_rx_datagram_checker_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/udpchk_pkg.sv
hw/rtl/udpchk_in_stage.sv
hw/rtl/udpchk_parse.sv
hw/rtl/udpchk_out_stage.sv
hw/rtl/udp_rx_datagram_checker_unit.sv
hw/rtl/udpchk_checker.sv
tb/udp_rx_datagram_checker_unit_test.sv
